// File: src/hcmg_pkg.sv
// Shared constants, shape tables and move direction codes for the Hilbert move generator.
package hcmg_pkg;

	localparam int MAX_ORDER = 8;
	localparam int LVL_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int ORD_W     = $clog2(MAX_ORDER + 1);

	localparam int ORDER_W   = 4;
	localparam int STEP_W    = 12;
	localparam int MOVE_W    = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 2'd2;

	typedef logic [1:0] shape_t;
	typedef logic [1:0] phase_t;

	typedef enum logic [1:0] {
		DIR_ZERO = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	localparam shape_t SH_A = 2'd0;
	localparam shape_t SH_B = 2'd1;
	localparam shape_t SH_C = 2'd2;
	localparam shape_t SH_D = 2'd3;

	// sub-shape entered before move k of a shape
	function automatic shape_t child_of(input shape_t sh, input phase_t ph);
		shape_t c;
		c = SH_A;
		case (sh)
			SH_A: case (ph)
				2'd0: c = SH_D;
				2'd1: c = SH_A;
				2'd2: c = SH_A;
				default: c = SH_B;
			endcase
			SH_B: case (ph)
				2'd0: c = SH_C;
				2'd1: c = SH_B;
				2'd2: c = SH_B;
				default: c = SH_A;
			endcase
			SH_C: case (ph)
				2'd0: c = SH_B;
				2'd1: c = SH_C;
				2'd2: c = SH_C;
				default: c = SH_D;
			endcase
			default: case (ph)
				2'd0: c = SH_A;
				2'd1: c = SH_D;
				2'd2: c = SH_D;
				default: c = SH_C;
			endcase
		endcase
		return c;
	endfunction

	function automatic dir_t move_x(input shape_t sh, input phase_t ph);
		dir_t d;
		d = DIR_ZERO;
		case (sh)
			SH_A: d = (ph == 2'd0) ? DIR_NEG : ((ph == 2'd2) ? DIR_POS : DIR_ZERO);
			SH_B: d = (ph == 2'd1) ? DIR_POS : DIR_ZERO;
			SH_C: d = (ph == 2'd0) ? DIR_POS : ((ph == 2'd2) ? DIR_NEG : DIR_ZERO);
			default: d = (ph == 2'd1) ? DIR_NEG : DIR_ZERO;
		endcase
		return d;
	endfunction

	function automatic dir_t move_y(input shape_t sh, input phase_t ph);
		dir_t d;
		d = DIR_ZERO;
		case (sh)
			SH_A: d = (ph == 2'd1) ? DIR_NEG : DIR_ZERO;
			SH_B: d = (ph == 2'd0) ? DIR_POS : ((ph == 2'd2) ? DIR_NEG : DIR_ZERO);
			SH_C: d = (ph == 2'd1) ? DIR_POS : DIR_ZERO;
			default: d = (ph == 2'd0) ? DIR_NEG : ((ph == 2'd2) ? DIR_POS : DIR_ZERO);
		endcase
		return d;
	endfunction

	function automatic logic [MOVE_W-1:0] scale(input dir_t d, input logic [STEP_W-1:0] s);
		logic [MOVE_W-1:0] r;
		r = '0;
		case (d)
			DIR_POS: r = {1'b0, s};
			DIR_NEG: r = MOVE_W'(0) - {1'b0, s};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: src/hilbert_curve_move_generator.sv
// Hilbert curve move generator: level stack walked one level per cycle.
// Sequence: a restart of order n refills the levels below the top one, searches the
//   deepest level and then emits its first move; a plain request searches upward from the
//   deepest level to the moving one, refills the levels below it, then emits.
// Requests: a new request is taken only once the last one is through; a request that yields
//   no move frees the block without an emit step; a result not yet taken holds the emit step.
// Reset: config to order 1, step 64, shape A; no curve running, output empty.
module hilbert_curve_move_generator
	import hcmg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MOVE_W-1:0]     move_dx,
	output logic [MOVE_W-1:0]     move_dy,
	output logic                  last_move,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [STEP_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DESC = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [ORDER_W-1:0] order_q;
	logic [STEP_W-1:0]  step_q;
	shape_t             start_q;

	shape_t             shape_q [MAX_ORDER];
	phase_t             phase_q [MAX_ORDER];

	logic [1:0]         state_q;
	logic [ORD_W-1:0]   n_q;
	logic [ORD_W-1:0]   cnt3_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               run_q;
	logic               moved_q;
	shape_t             par_shape_q;
	phase_t             par_phase_q;
	shape_t             mv_shape_q;
	phase_t             mv_phase_q;
	logic               last_q;
	logic               out_valid_q;

	logic [ORD_W-1:0]   n_clamp;
	logic [LVL_W-1:0]   n_m1;
	shape_t             rd_shape;
	phase_t             rd_phase;
	shape_t             child;
	logic               in_acc;
	logic               all3;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign n_clamp = (32'(order_q) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(order_q);
	assign n_m1    = LVL_W'(n_q - 1'b1);
	assign rd_shape = shape_q[lvl_q];
	assign rd_phase = phase_q[lvl_q];
	assign child    = child_of(par_shape_q, par_phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(1);
			step_q  <= STEP_W'(64);
			start_q <= SH_A;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ORDER: order_q <= cfg_data[ORDER_W-1:0];
				REG_STEP:  step_q  <= cfg_data;
				REG_SHAPE: start_q <= cfg_data[1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			cnt3_q      <= '0;
			lvl_q       <= '0;
			run_q       <= 1'b0;
			moved_q     <= 1'b0;
			par_shape_q <= SH_A;
			par_phase_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_ORDER; i++) begin
				shape_q[i] <= SH_A;
				phase_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (restart) begin
							if (n_clamp == '0) begin
								run_q <= 1'b0;
							end else begin
								n_q         <= n_clamp;
								shape_q[0]  <= start_q;
								phase_q[0]  <= '0;
								par_shape_q <= start_q;
								par_phase_q <= '0;
								cnt3_q      <= '0;
								run_q       <= 1'b1;
								moved_q     <= 1'b0;
								if (n_clamp == ORD_W'(1)) begin
									lvl_q   <= '0;
									state_q <= ST_SRCH;
								end else begin
									lvl_q   <= LVL_W'(1);
									state_q <= ST_DESC;
								end
							end
						end else if (run_q) begin
							moved_q <= 1'b0;
							lvl_q   <= n_m1;
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (rd_phase != 2'd3) begin
						phase_q[lvl_q] <= rd_phase + 2'd1;
						if (rd_phase == 2'd2)
							cnt3_q <= cnt3_q + 1'b1;
						par_shape_q <= rd_shape;
						par_phase_q <= rd_phase + 2'd1;
						moved_q     <= 1'b1;
						if (lvl_q == n_m1) begin
							state_q <= ST_EMIT;
						end else begin
							lvl_q   <= lvl_q + 1'b1;
							state_q <= ST_DESC;
						end
					end else if (lvl_q == '0) begin
						// every level exhausted
						run_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
				ST_DESC: begin
					shape_q[lvl_q] <= child;
					phase_q[lvl_q] <= '0;
					if (moved_q && rd_phase == 2'd3)
						cnt3_q <= cnt3_q - 1'b1;
					par_shape_q <= child;
					par_phase_q <= '0;
					if (lvl_q == n_m1)
						state_q <= moved_q ? ST_EMIT : ST_SRCH;
					else
						lvl_q <= lvl_q + 1'b1;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (last_q)
							run_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// move payload, captured when the moving level is found and driven out at the emit step
	always_ff @(posedge clk) begin
		if (state_q == ST_SRCH && rd_phase != 2'd3) begin
			mv_shape_q <= rd_shape;
			mv_phase_q <= rd_phase;
			last_q     <= (lvl_q == n_m1) && (rd_phase == 2'd2)
				&& (ORD_W'(cnt3_q + 1'b1) == n_q);
		end
		if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
			move_dx   <= scale(move_x(mv_shape_q, mv_phase_q), step_q);
			move_dy   <= scale(move_y(mv_shape_q, mv_phase_q), step_q);
			last_move <= last_q;
		end
	end

	always_comb begin
		all3 = 1'b1;
		for (int i = 0; i < MAX_ORDER; i++) begin
			if (ORD_W'(i) < n_q && phase_q[i] != 2'd3)
				all3 = 1'b0;
		end
	end

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result appeared without an emit step");

	a_cnt3_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cnt3_q <= n_q))
		else $error("exhausted level count exceeds curve order");

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH || state_q == ST_DESC) |-> (ORD_W'(lvl_q) < n_q))
		else $error("stack level pointer beyond curve order");

	a_last_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && last_q) |-> all3)
		else $error("last move flagged with levels still open");

endmodule
